[hw/rtl/pedal_plausibility_ready_to_drive_defines.svh]
// Assertion macros for the pedal plausibility RTL, used by the state stage (pprtd_ctrl).
`ifndef PEDAL_PLAUSIBILITY_READY_TO_DRIVE_DEFINES_SVH
`define PEDAL_PLAUSIBILITY_READY_TO_DRIVE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication check
`define PPRTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pprtd: same-cycle check failed");

// Next-cycle implication check
`define PPRTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pprtd: next-cycle check failed");

`else

`define PPRTD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PPRTD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hw/rtl/pprtd_pkg.sv]
// Shared types and constants for the pedal plausibility / ready-to-drive block.
package pprtd_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_IMPL_LIMIT    = 3'd1,
        REG_BUZZER_MS     = 3'd2,
        REG_LOCKOUT_MS    = 3'd3,
        REG_BRAKE_THR     = 3'd4,
        REG_PEDAL_THR     = 3'd5
    } pprtd_reg_t;

    // Register reset values
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd1000;
    localparam logic [15:0] RST_IMPL_LIMIT    = 16'd100;
    localparam logic [15:0] RST_BUZZER_MS     = 16'd1000;
    localparam logic [15:0] RST_LOCKOUT_MS    = 16'd10000;
    localparam logic [14:0] RST_BRAKE_THR     = 15'd13107;
    localparam logic [14:0] RST_PEDAL_THR     = 15'd1638;

    // Limits in microseconds: (ms + 1) * 1000 fits in 27 bits
    localparam int LIM_W = 27;
    // Lockout duration in microseconds before saturation: ms * 1000 fits in 26 bits
    localparam int LOCK_W = 26;

    // Positions: Q.14, offset by 0.125 (2048) so they stay unsigned in the datapath
    localparam int POS_W = 15;
    localparam logic [15:0] POS_OFFSET = 16'd2048;
    // 5 * |diff| must exceed 1.0 in Q.14
    localparam logic [17:0] DIFF_LIMIT = 18'd16384;

    // Result word layout
    localparam int OUT_DATA_W    = 24;
    localparam int OUT_BUZZER    = 0;
    localparam int OUT_RUNNING   = 1;
    localparam int OUT_IMPLAUS   = 2;
    localparam int OUT_SHUTDOWN  = 3;
    localparam int OUT_AVG_LSB   = 4;

    // Live configuration as seen by the datapath
    typedef struct packed {
        logic [15:0]      period;
        logic [14:0]      pedal_thr;
        logic [14:0]      brake_thr;
        logic [LIM_W-1:0] imp_lim_us;
        logic [LIM_W-1:0] buz_lim_us;
    } pprtd_cfg_t;

    // Per-sample evaluation handed to the state stage
    typedef struct packed {
        logic        check_fail;  // plausibility check active and failing
        logic        arm;         // brake pressed with cockpit switch
        logic [15:0] avg;         // signed Q.14 throttle mean
    } pprtd_eval_t;

endpackage

[hw/rtl/pprtd_cfg.sv]
// Configuration registers and derived microsecond limits.
module pprtd_cfg
    import pprtd_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pprtd_cfg_t            cfg,
    output logic [TIMER_BITS-1:0] lockout_us
);

    localparam int SAT_W = (TIMER_BITS > LOCK_W) ? TIMER_BITS : LOCK_W;

    logic [15:0] period_reg;
    logic [15:0] imp_ms_reg;
    logic [15:0] buz_ms_reg;
    logic [15:0] lock_ms_reg;
    logic [14:0] brake_thr_reg;
    logic [14:0] pedal_thr_reg;

    logic [LIM_W-1:0]      imp_lim_reg, imp_lim_next;
    logic [LIM_W-1:0]      buz_lim_reg, buz_lim_next;
    logic [TIMER_BITS-1:0] lock_us_reg, lock_us_next;

    logic [LOCK_W-1:0] lock_prod;
    logic [SAT_W-1:0]  lock_wide;
    logic [SAT_W-1:0]  timer_max;
    logic [SAT_W-1:0]  lock_sat;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= RST_SAMPLE_PERIOD;
            imp_ms_reg    <= RST_IMPL_LIMIT;
            buz_ms_reg    <= RST_BUZZER_MS;
            lock_ms_reg   <= RST_LOCKOUT_MS;
            brake_thr_reg <= RST_BRAKE_THR;
            pedal_thr_reg <= RST_PEDAL_THR;
        end else if (cfg_wr_en) begin
            case (pprtd_reg_t'(cfg_addr))
                REG_SAMPLE_PERIOD: period_reg    <= cfg_wdata;
                REG_IMPL_LIMIT:    imp_ms_reg    <= cfg_wdata;
                REG_BUZZER_MS:     buz_ms_reg    <= cfg_wdata;
                REG_LOCKOUT_MS:    lock_ms_reg   <= cfg_wdata;
                REG_BRAKE_THR:     brake_thr_reg <= cfg_wdata[14:0];
                REG_PEDAL_THR:     pedal_thr_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Time limits: floor(t/1000) > ms  <=>  t >= (ms + 1) * 1000
    assign imp_lim_next = (LIM_W'(imp_ms_reg) + LIM_W'(1)) * LIM_W'(1000);
    assign buz_lim_next = (LIM_W'(buz_ms_reg) + LIM_W'(1)) * LIM_W'(1000);

    // Lockout length, saturated to the timer width
    assign lock_prod    = LOCK_W'(lock_ms_reg) * LOCK_W'(1000);
    assign lock_wide    = SAT_W'(lock_prod);
    assign timer_max    = SAT_W'({TIMER_BITS{1'b1}});
    assign lock_sat     = (lock_wide > timer_max) ? timer_max : lock_wide;
    assign lock_us_next = lock_sat[TIMER_BITS-1:0];

    // Derived values follow the registers in the next cycle
    always_ff @(posedge aclk) begin
        imp_lim_reg <= imp_lim_next;
        buz_lim_reg <= buz_lim_next;
        lock_us_reg <= lock_us_next;
    end

    assign cfg.period     = period_reg;
    assign cfg.pedal_thr  = pedal_thr_reg;
    assign cfg.brake_thr  = brake_thr_reg;
    assign cfg.imp_lim_us = imp_lim_reg;
    assign cfg.buz_lim_us = buz_lim_reg;
    assign lockout_us     = lock_us_reg;

endmodule

[hw/rtl/pprtd_front.sv]
// Sample pipeline: input register, code-to-position scaling, range and plausibility flags.
module pprtd_front
    import pprtd_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_BITS-1:0] app0_code,
    input  logic [ADC_BITS-1:0] app1_code,
    input  logic [ADC_BITS-1:0] brake_code,
    input  logic                cockpit_switch,
    input  pprtd_cfg_t          cfg,
    output logic                ev_valid,
    input  logic                ev_ready,
    output pprtd_eval_t         ev
);

    localparam longint unsigned FS = (64'd1 << ADC_BITS) - 64'd1;
    localparam int SH    = ADC_BITS + 1;      // reciprocal shift
    localparam int EST_W = ADC_BITS + 16;     // code * reciprocal
    localparam int NUM_W = ADC_BITS + 20;     // exact numerator
    localparam int RNG_W = ADC_BITS + 9;      // 330 * code

    // Voltage windows, exact in code units
    localparam logic [RNG_W-1:0] R0_LO = RNG_W'(25 * FS);
    localparam logic [RNG_W-1:0] R0_HI = RNG_W'(225 * FS);
    localparam logic [RNG_W-1:0] R1_LO = RNG_W'(30 * FS);
    localparam logic [RNG_W-1:0] R1_HI = RNG_W'(270 * FS);

    // Stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    // Stage 1: input register
    logic [ADC_BITS-1:0] c1_reg [3];
    logic                sw1_reg;

    // Stage 2: reciprocal estimate and exact numerator
    logic [EST_W-1:0] est_c  [3];
    logic [NUM_W-1:0] num_c  [3];
    logic [EST_W-1:0] est2_reg [3];
    logic [NUM_W-1:0] num2_reg [3];
    logic             bad2_reg, sw2_reg;
    logic [RNG_W-1:0] v0_scaled, v1_scaled;
    logic             range_bad;

    // Stage 3: quotient estimate and (q + 1) * D
    logic [POS_W-1:0] q0_c  [3];
    logic [NUM_W-1:0] qd_c  [3];
    logic [POS_W-1:0] q3_reg [3];
    logic [NUM_W-1:0] qd3_reg [3];
    logic [NUM_W-1:0] num3_reg [3];
    logic             bad3_reg, sw3_reg;

    // Stage 4: corrected positions
    logic [POS_W-1:0] q_c   [3];
    logic [POS_W-1:0] q4_reg [3];
    logic             bad4_reg, sw4_reg;

    // Stage 5: evaluation
    pprtd_eval_t ev_next, ev_reg;
    logic [15:0] diff;
    logic [17:0] diff5;
    logic [15:0] pedal_lim, brake_lim;
    logic        pedal_over, diff_big;
    logic [16:0] sum_q;

    // Ready chain: a stage loads when empty or when its content moves on
    assign adv5     = !v5_reg || ev_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // Sensor range windows
    assign v0_scaled = RNG_W'(c1_reg[0]) * RNG_W'(330);
    assign v1_scaled = RNG_W'(c1_reg[1]) * RNG_W'(330);
    assign range_bad = !((v0_scaled > R0_LO) && (v0_scaled < R0_HI)) ||
                       !((v1_scaled > R1_LO) && (v1_scaled < R1_HI));

    // Per-sensor scaling lanes; lane 1 is the second pedal sensor
    // pos = floor((A*c + B) / D), via reciprocal estimate plus one correction step
    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam longint unsigned LA = (i == 1) ? 64'd45056 : 64'd270336;
        localparam longint unsigned LB = (i == 1) ? FS : 5 * FS;
        localparam longint unsigned LD = (i == 1) ? 2 * FS : 10 * FS;
        localparam longint unsigned LM = (LA << SH) / LD;

        assign est_c[i] = EST_W'(c1_reg[i]) * EST_W'(LM);
        assign num_c[i] = NUM_W'(c1_reg[i]) * NUM_W'(LA) + NUM_W'(LB);
        assign q0_c[i]  = est2_reg[i][EST_W-1:SH];
        assign qd_c[i]  = (NUM_W'(q0_c[i]) + NUM_W'(1)) * NUM_W'(LD);
        assign q_c[i]   = q3_reg[i] + POS_W'(num3_reg[i] >= qd3_reg[i]);
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            c1_reg[0] <= app0_code;
            c1_reg[1] <= app1_code;
            c1_reg[2] <= brake_code;
            sw1_reg   <= cockpit_switch;
        end
        if (adv2) begin
            for (int i = 0; i < 3; i++) begin
                est2_reg[i] <= est_c[i];
                num2_reg[i] <= num_c[i];
            end
            bad2_reg <= range_bad;
            sw2_reg  <= sw1_reg;
        end
        if (adv3) begin
            for (int i = 0; i < 3; i++) begin
                q3_reg[i]   <= q0_c[i];
                qd3_reg[i]  <= qd_c[i];
                num3_reg[i] <= num2_reg[i];
            end
            bad3_reg <= bad2_reg;
            sw3_reg  <= sw2_reg;
        end
        if (adv4) begin
            for (int i = 0; i < 3; i++) begin
                q4_reg[i] <= q_c[i];
            end
            bad4_reg <= bad3_reg;
            sw4_reg  <= sw3_reg;
        end
        if (adv5) begin
            ev_reg <= ev_next;
        end
    end

    // Plausibility and arming flags, throttle mean
    assign diff       = (q4_reg[0] >= q4_reg[1]) ? 16'(q4_reg[0] - q4_reg[1])
                                                 : 16'(q4_reg[1] - q4_reg[0]);
    assign diff5      = (18'(diff) << 2) + 18'(diff);
    assign diff_big   = diff5 > DIFF_LIMIT;
    assign pedal_lim  = 16'(cfg.pedal_thr) + POS_OFFSET;
    assign brake_lim  = 16'(cfg.brake_thr) + POS_OFFSET;
    assign pedal_over = (16'(q4_reg[0]) >= pedal_lim) || (16'(q4_reg[1]) >= pedal_lim);
    assign sum_q      = 17'(q4_reg[0]) + 17'(q4_reg[1]) + 17'd1;

    always_comb begin
        ev_next.check_fail = (pedal_over || bad4_reg) && (diff_big || bad4_reg);
        ev_next.arm        = (16'(q4_reg[2]) >= brake_lim) && sw4_reg;
        ev_next.avg        = sum_q[16:1] - POS_OFFSET;
    end

    assign ev_valid = v5_reg;
    assign ev       = ev_reg;

endmodule

[hw/rtl/pprtd_ctrl.sv]
// State stage: implausibility timer, shutdown and lockout, ready-to-drive sequence, result register.
`include "pedal_plausibility_ready_to_drive_defines.svh"

module pprtd_ctrl
    import pprtd_pkg::*;
#(
    parameter int TIMER_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ev_valid,
    output logic                  ev_ready,
    input  pprtd_eval_t           ev,
    input  pprtd_cfg_t            cfg,
    input  logic [TIMER_BITS-1:0] lockout_us,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CMP_W = (TIMER_BITS > LIM_W) ? TIMER_BITS : LIM_W;

    logic                  run_reg, run_next;
    logic                  iflag_reg, iflag_next;
    logic [TIMER_BITS-1:0] itime_reg, itime_next;
    logic                  rreq_reg, rreq_next;
    logic                  buzz_reg, buzz_next;
    logic [TIMER_BITS-1:0] btime_reg, btime_next;
    logic [TIMER_BITS-1:0] lock_reg, lock_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  accept;
    logic [TIMER_BITS-1:0] period_t;
    logic                  shut;
    logic                  started;

    // Saturating timer advance
    function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] a,
                                                      input logic [TIMER_BITS-1:0] b);
        logic [TIMER_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

    assign ev_ready = !m_valid_reg || m_tready;
    assign accept   = ev_valid && ev_ready;
    assign period_t = TIMER_BITS'(cfg.period);

    // Next state for one sample
    always_comb begin
        run_next    = run_reg;
        iflag_next  = iflag_reg;
        itime_next  = itime_reg;
        rreq_next   = rreq_reg;
        buzz_next   = buzz_reg;
        btime_next  = btime_reg;
        lock_next   = lock_reg;
        shut        = 1'b0;
        started     = 1'b0;
        m_data_next = '0;

        if (lock_reg != '0) begin
            // Lockout: sample ignored, count remaining time down
            lock_next = (lock_reg > period_t) ? lock_reg - period_t : '0;
        end else begin
            // Implausibility timing while running
            if (run_reg && ev.check_fail) begin
                if (!iflag_reg) begin
                    iflag_next = 1'b1;
                    itime_next = '0;
                end else begin
                    itime_next = sat_add(itime_reg, period_t);
                end
                if (CMP_W'(itime_next) >= CMP_W'(cfg.imp_lim_us)) begin
                    shut       = 1'b1;
                    run_next   = 1'b0;
                    iflag_next = 1'b0;
                    itime_next = '0;
                    lock_next  = lockout_us;
                end
            end else begin
                iflag_next = 1'b0;
                itime_next = '0;
            end

            // Ready-to-drive sequence, skipped on a shutdown sample
            if (!shut) begin
                rreq_next = rreq_reg || ev.arm;
                if (rreq_next && !run_reg && !buzz_reg) begin
                    buzz_next  = 1'b1;
                    btime_next = '0;
                    rreq_next  = 1'b0;
                    started    = 1'b1;
                end
                if (buzz_next) begin
                    if (!started) begin
                        btime_next = sat_add(btime_reg, period_t);
                    end
                    if (CMP_W'(btime_next) >= CMP_W'(cfg.buz_lim_us)) begin
                        buzz_next = 1'b0;
                        run_next  = 1'b1;
                    end
                end
            end

            m_data_next[OUT_BUZZER]   = buzz_next;
            m_data_next[OUT_RUNNING]  = run_next;
            m_data_next[OUT_IMPLAUS]  = iflag_next || shut;
            m_data_next[OUT_SHUTDOWN] = shut;
            m_data_next[OUT_AVG_LSB +: 16] = ev.avg;
        end
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            iflag_reg   <= 1'b0;
            itime_reg   <= '0;
            rreq_reg    <= 1'b0;
            buzz_reg    <= 1'b0;
            btime_reg   <= '0;
            lock_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                run_reg   <= run_next;
                iflag_reg <= iflag_next;
                itime_reg <= itime_next;
                rreq_reg  <= rreq_next;
                buzz_reg  <= buzz_next;
                btime_reg <= btime_next;
                lock_reg  <= lock_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Running and buzzing are exclusive phases
    `PPRTD_ASSERT_IMP(a_run_buzz_excl, aclk, aresetn, run_reg, !buzz_reg)
    // Implausibility is only timed while running
    `PPRTD_ASSERT_IMP(a_iflag_needs_run, aclk, aresetn, iflag_reg, run_reg)
    // A sample taken during lockout yields an all-zero result
    `PPRTD_ASSERT_NXT(a_lockout_zero, aclk, aresetn, accept && (lock_reg != '0),
                      m_data_reg == '0)
    // A shutdown transfer leaves the vehicle stopped and starts the lockout
    `PPRTD_ASSERT_NXT(a_shut_locks, aclk, aresetn, accept && shut,
                      !run_reg && (lock_reg == lockout_us))

endmodule

[hw/rtl/pedal_plausibility_ready_to_drive.sv]
// Top level of the pedal plausibility check with ready-to-drive sequencing.
//
// One sample (two pedal sensor codes, brake code, cockpit switch) is taken per
// transfer on the s_ side and produces exactly one result transfer on the m_ side.
// Samples may be sent every clock cycle while m_tready is held high. The input
// register and three more stages scale the codes to positions (reciprocal
// multiply, then one exact correction), one stage forms the plausibility and
// arming flags, and the last stage updates the timers and state and holds the
// result. While m_tready is low the six stages fill up and s_tready drops.
// Configuration registers are to be written through cfg_wr_en, cfg_addr and
// cfg_wdata only while no sample is in flight; the block itself does not enforce
// this. Derived limits are registered and follow a write in the next cycle.
module pedal_plausibility_ready_to_drive
    import pprtd_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int TIMER_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Sample channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // app0_code, app1_code, brake_code, cockpit_switch, zero fill
    input  logic [((3*ADC_BITS+8)/8)*8-1:0] s_tdata,
    // Result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // buzzer_on, running, implausible, shutdown, throttle_avg[15:0], zero fill
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    pprtd_cfg_t            cfg;
    logic [TIMER_BITS-1:0] lockout_us;
    pprtd_eval_t           ev;
    logic                  ev_valid;
    logic                  ev_ready;

    logic [ADC_BITS-1:0] app0_code;
    logic [ADC_BITS-1:0] app1_code;
    logic [ADC_BITS-1:0] brake_code;
    logic                cockpit_switch;

    // Unpack the sample word
    assign app0_code      = s_tdata[ADC_BITS-1:0];
    assign app1_code      = s_tdata[2*ADC_BITS-1:ADC_BITS];
    assign brake_code     = s_tdata[3*ADC_BITS-1:2*ADC_BITS];
    assign cockpit_switch = s_tdata[3*ADC_BITS];

    pprtd_cfg #(
        .TIMER_BITS (TIMER_BITS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .lockout_us (lockout_us)
    );

    pprtd_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .app0_code      (app0_code),
        .app1_code      (app1_code),
        .brake_code     (brake_code),
        .cockpit_switch (cockpit_switch),
        .cfg            (cfg),
        .ev_valid       (ev_valid),
        .ev_ready       (ev_ready),
        .ev             (ev)
    );

    pprtd_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ev_valid   (ev_valid),
        .ev_ready   (ev_ready),
        .ev         (ev),
        .cfg        (cfg),
        .lockout_us (lockout_us),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the pedal plausibility and ready-to-drive block.
`timescale 1ns / 100ps

module tb;
    import pprtd_pkg::*;

    localparam int ADC_W          = 12;
    localparam int S_DATA_W       = ((3*ADC_W+8)/8)*8;
    localparam int CODE_MAX       = 4095;
    localparam int PHASE_ITEMS    = 210;
    localparam int STALL_LEN      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 12;
    localparam longint unsigned TIMER_CAP = 64'hFFFF_FFFF;

    // One sample period, packed as it travels on s_tdata
    typedef struct packed {
        logic        sw;
        logic [11:0] brake;
        logic [11:0] app1;
        logic [11:0] app0;
    } sample_t;

    typedef struct {
        logic        buzzer_on;
        logic        running;
        logic        implausible;
        logic        shutdown;
        logic [15:0] throttle_avg;
    } status_t;

    typedef struct {
        logic [15:0] period_us;
        logic [15:0] impl_limit_ms;
        logic [15:0] buzzer_ms;
        logic [15:0] lockout_ms;
        logic [15:0] brake_thr;
        logic [15:0] pedal_thr;
    } setup_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // app0_code, app1_code, brake_code, cockpit_switch, zero fill
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // buzzer_on, running, implausible, shutdown, throttle_avg[15:0], zero fill
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Vehicle model: configuration
    longint unsigned cfg_period     = 64'(RST_SAMPLE_PERIOD);
    longint unsigned cfg_impl_limit = 64'(RST_IMPL_LIMIT);
    longint unsigned cfg_buzzer_ms  = 64'(RST_BUZZER_MS);
    longint unsigned cfg_lockout_ms = 64'(RST_LOCKOUT_MS);
    longint          cfg_brake_thr  = 64'(RST_BRAKE_THR);
    longint          cfg_pedal_thr  = 64'(RST_PEDAL_THR);

    // Vehicle model: state
    bit              run_on        = 1'b0;
    bit              impl_on       = 1'b0;
    bit              ready_pending = 1'b0;
    bit              buzz_on       = 1'b0;
    longint unsigned impl_elapsed  = 0;
    longint unsigned buzz_elapsed  = 0;
    longint unsigned lockout_left  = 0;

    status_t expected_q[$];
    int      src_idle_pct  = 8;
    int      sink_idle_pct = 58;
    bit      stall_request = 1'b0;
    int      stall_left    = 0;
    int      sent_cnt      = 0;
    int      results_seen  = 0;
    int      mismatches    = 0;
    int      quiet_cycles  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pedal_plausibility_ready_to_drive #(
        .ADC_BITS   (ADC_W),
        .TIMER_BITS (32)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Position from app0 or brake code: 1.65*code/FS - 0.125, Q.14, rounded half up
    function automatic longint wide_pos(logic [11:0] code);
        return (longint'(code) * 270336 + 5 * CODE_MAX) / (10 * CODE_MAX) - 2048;
    endfunction

    // Position from app1 code: 1.375*code/FS - 0.125
    function automatic longint narrow_pos(logic [11:0] code);
        return (longint'(code) * 45056 + CODE_MAX) / (2 * CODE_MAX) - 2048;
    endfunction

    function automatic longint unsigned timer_add(longint unsigned a, longint unsigned b);
        longint unsigned sum;
        sum = a + b;
        return (sum > TIMER_CAP) ? TIMER_CAP : sum;
    endfunction

    // Advance the vehicle model by one sample and return the status it reports
    function automatic status_t step_vehicle(sample_t smp);
        status_t st;
        longint  p0, p1, pb, diff, avg;
        int      c0, c1;
        bit      ok0, ok1, fault, tripped, started;
        st = '{buzzer_on: 1'b0, running: 1'b0, implausible: 1'b0, shutdown: 1'b0,
               throttle_avg: 16'd0};
        // samples during lockout are dropped
        if (lockout_left > 0) begin
            lockout_left = (lockout_left > cfg_period) ? lockout_left - cfg_period : 0;
            return st;
        end
        p0   = wide_pos(smp.app0);
        p1   = narrow_pos(smp.app1);
        pb   = wide_pos(smp.brake);
        avg  = (p0 + p1 + 4097) / 2 - 2048;
        diff = (p0 > p1) ? p0 - p1 : p1 - p0;
        c0   = int'(smp.app0);
        c1   = int'(smp.app1);
        ok0  = (25 * CODE_MAX < 330 * c0) && (330 * c0 < 225 * CODE_MAX);
        ok1  = (30 * CODE_MAX < 330 * c1) && (330 * c1 < 270 * CODE_MAX);
        fault = run_on && (p0 >= cfg_pedal_thr || p1 >= cfg_pedal_thr || !ok0 || !ok1) &&
                (5 * diff > 16384 || !ok0 || !ok1);
        tripped = 1'b0;
        // implausibility timing and shutdown
        if (fault) begin
            if (!impl_on) begin
                impl_on      = 1'b1;
                impl_elapsed = 0;
            end else begin
                impl_elapsed = timer_add(impl_elapsed, cfg_period);
            end
            if (impl_elapsed / 1000 > cfg_impl_limit) begin
                tripped      = 1'b1;
                run_on       = 1'b0;
                impl_on      = 1'b0;
                impl_elapsed = 0;
                lockout_left = (cfg_lockout_ms * 1000 > TIMER_CAP) ? TIMER_CAP :
                               cfg_lockout_ms * 1000;
            end
        end else begin
            impl_on      = 1'b0;
            impl_elapsed = 0;
        end
        // ready-to-drive: arm request, buzzer, then running
        if (!tripped) begin
            started = 1'b0;
            if (pb >= cfg_brake_thr && smp.sw)
                ready_pending = 1'b1;
            if (ready_pending && !run_on && !buzz_on) begin
                buzz_on       = 1'b1;
                buzz_elapsed  = 0;
                ready_pending = 1'b0;
                started       = 1'b1;
            end
            if (buzz_on) begin
                if (!started)
                    buzz_elapsed = timer_add(buzz_elapsed, cfg_period);
                if (buzz_elapsed / 1000 > cfg_buzzer_ms) begin
                    buzz_on = 1'b0;
                    run_on  = 1'b1;
                end
            end
        end
        st.buzzer_on    = buzz_on;
        st.running      = run_on;
        st.implausible  = impl_on || tripped;
        st.shutdown     = tripped;
        st.throttle_avg = avg[15:0];
        return st;
    endfunction

    function automatic sample_t make_sample(int a0, int a1, int br, bit sw);
        sample_t smp;
        smp.app0  = a0[11:0];
        smp.app1  = a1[11:0];
        smp.brake = br[11:0];
        smp.sw    = sw;
        return smp;
    endfunction

    // Pedal sample: sensors agree within jitter, or disagree / leave their range
    function automatic sample_t pedal_sample(bit agree);
        int c0, c1, off;
        c0 = $urandom_range(2780, 320);
        if (agree) begin
            off = int'($urandom_range(900)) - 450;
        end else if ($urandom_range(1)) begin
            off = $urandom_range(2000, 650);
            if ($urandom_range(1))
                off = -off;
        end else begin
            off = 0;
        end
        c1 = c0 * 6 / 5 + off;
        if (c1 < 0)
            c1 = 0;
        if (c1 > CODE_MAX)
            c1 = CODE_MAX;
        // range fault on one sensor
        if (!agree && off == 0) begin
            case ($urandom_range(3))
                0: c0 = $urandom_range(310);
                1: c0 = $urandom_range(CODE_MAX, 2793);
                2: c1 = $urandom_range(372);
                default: c1 = $urandom_range(CODE_MAX, 3351);
            endcase
        end
        return make_sample(c0, c1, $urandom_range(CODE_MAX), $urandom_range(9) == 0);
    endfunction

    function automatic sample_t arm_sample();
        sample_t smp;
        smp       = pedal_sample(1'b1);
        smp.brake = 12'($urandom_range(CODE_MAX, 2200));
        smp.sw    = 1'b1;
        return smp;
    endfunction

    function automatic sample_t noise_sample();
        return make_sample($urandom_range(CODE_MAX), $urandom_range(CODE_MAX),
                           $urandom_range(CODE_MAX), 1'($urandom_range(1)));
    endfunction

    // Offer one sample, with random gaps, and predict its status once it is taken
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(smp);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_cnt++;
        expected_q.push_back(step_vehicle(smp));
    endtask

    // Stop sending and let every pending status come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input pprtd_reg_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic load_setup(input setup_t cfg);
        put_reg(REG_SAMPLE_PERIOD, cfg.period_us);
        put_reg(REG_IMPL_LIMIT, cfg.impl_limit_ms);
        put_reg(REG_BUZZER_MS, cfg.buzzer_ms);
        put_reg(REG_LOCKOUT_MS, cfg.lockout_ms);
        put_reg(REG_BRAKE_THR, cfg.brake_thr);
        put_reg(REG_PEDAL_THR, cfg.pedal_thr);
        cfg_wr_en <= 1'b0;
        cfg_period     = 64'(cfg.period_us);
        cfg_impl_limit = 64'(cfg.impl_limit_ms);
        cfg_buzzer_ms  = 64'(cfg.buzzer_ms);
        cfg_lockout_ms = 64'(cfg.lockout_ms);
        cfg_brake_thr  = 64'(cfg.brake_thr[14:0]);
        cfg_pedal_thr  = 64'(cfg.pedal_thr[14:0]);
        // derived limits settle after the write
        repeat (4) @(posedge aclk);
    endtask

    // Random burst of driving: arming, agreeing pedals, faults or noise
    task automatic send_burst();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            repeat ($urandom_range(2, 1)) send_sample(arm_sample());
            repeat ($urandom_range(6, 1)) send_sample(pedal_sample(1'b1));
        end else if (pick < 55) begin
            repeat ($urandom_range(10, 1)) send_sample(pedal_sample(1'b1));
        end else if (pick < 85) begin
            repeat ($urandom_range(8, 1)) send_sample(pedal_sample(1'b0));
        end else begin
            repeat ($urandom_range(4, 1)) send_sample(noise_sample());
        end
    endtask

    task automatic run_phase(input setup_t cfg, input int src_pct, input int sink_pct);
        int sent_start;
        wait_idle();
        load_setup(cfg);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent_start    = sent_cnt;
        while (sent_cnt - sent_start < PHASE_ITEMS)
            send_burst();
    endtask

    // Reset configuration: throttle extremes, arming with the default buzzer
    task automatic test_reset_defaults();
        send_sample(make_sample(0, 0, 0, 1'b0));
        send_sample(make_sample(CODE_MAX, CODE_MAX, CODE_MAX, 1'b1));
        send_sample(make_sample(CODE_MAX, 0, 0, 1'b0));
    endtask

    // Buzzer ends, brake threshold edge, switch needed, arming while running
    task automatic test_ready_to_drive();
        wait_idle();
        load_setup('{period_us: 16'd1000, impl_limit_ms: 16'd1, buzzer_ms: 16'd0,
                     lockout_ms: 16'd2, brake_thr: RST_BRAKE_THR, pedal_thr: RST_PEDAL_THR});
        send_sample(make_sample(1000, 1200, 2295, 1'b1));
        send_sample(make_sample(1000, 1200, CODE_MAX, 1'b0));
        send_sample(make_sample(1000, 1200, 2296, 1'b1));
        send_sample(make_sample(1000, 1200, 0, 1'b0));
    endtask

    // Difference fault, range faults on both sensors, shutdown, lockout, rearm
    task automatic test_plausibility_shutdown();
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(2000, 1500, 0, 1'b0));
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(1000, 0, 0, 1'b0));
        send_sample(make_sample(1000, CODE_MAX, 0, 1'b0));
        send_sample(make_sample(CODE_MAX, CODE_MAX, 0, 1'b0));
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(2000, 2400, 0, 1'b0));
        send_sample(make_sample(0, 1200, 0, 1'b0));
    endtask

    // Random driving over several register settings and idle patterns
    task automatic test_random_traffic();
        setup_t mixed;
        run_phase('{period_us: 16'd1000, impl_limit_ms: 16'd2, buzzer_ms: 16'd1,
                    lockout_ms: 16'd5, brake_thr: RST_BRAKE_THR, pedal_thr: RST_PEDAL_THR},
                  8, 58);
        run_phase('{period_us: 16'hFFFF, impl_limit_ms: 16'd0, buzzer_ms: 16'd0,
                    lockout_ms: 16'd400, brake_thr: 16'd0, pedal_thr: 16'd0}, 8, 58);
        run_phase('{period_us: 16'hFFFF, impl_limit_ms: 16'hFFFF, buzzer_ms: 16'hFFFF,
                    lockout_ms: 16'd0, brake_thr: 16'h7FFF, pedal_thr: 16'h7FFF}, 58, 8);
        // period of zero freezes every timer
        run_phase('{period_us: 16'd0, impl_limit_ms: 16'd3, buzzer_ms: 16'd2,
                    lockout_ms: 16'd7, brake_thr: 16'd0, pedal_thr: 16'd0}, 58, 8);
        run_phase('{period_us: 16'd500, impl_limit_ms: 16'd1, buzzer_ms: 16'd0,
                    lockout_ms: 16'd3, brake_thr: 16'd9000, pedal_thr: 16'd800}, 0, 0);
        // thresholds with the unused top bit set
        mixed = '{period_us: 16'd20000, impl_limit_ms: 16'd40, buzzer_ms: 16'd2,
                  lockout_ms: 16'd200,
                  brake_thr: {1'b1, 15'($urandom_range(16000, 6000))},
                  pedal_thr: {1'b1, 15'($urandom_range(4000))}};
        run_phase(mixed, 0, 0);
    endtask

    // Receiver holds off while samples keep coming, then the sender drains
    task automatic test_backpressure();
        wait_idle();
        load_setup('{period_us: 16'd500, impl_limit_ms: 16'd1, buzzer_ms: 16'd0,
                     lockout_ms: 16'd3, brake_thr: 16'd9000, pedal_thr: 16'd800});
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_request = 1'b1;
        repeat (40) send_sample(($urandom_range(3) == 0) ? arm_sample() :
                                pedal_sample(1'($urandom_range(1))));
        wait_idle();
        repeat (20) send_sample(pedal_sample(1'($urandom_range(1))));
    endtask

    // Receiver: random ready, with a long hold-off on request
    always @(posedge aclk) begin
        if (stall_request) begin
            stall_left    = STALL_LEN;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic void check_field(string field, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("status %0d: %s expected %0d, got %0d", results_seen, field, want, got);
        end
    endfunction

    // Compare each status transfer with the oldest prediction
    always @(posedge aclk) begin : check_status
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status %0d arrived with no sample pending", results_seen);
            end else begin
                want = expected_q.pop_front();
                check_field("buzzer_on", 32'(want.buzzer_on), 32'(m_tdata[OUT_BUZZER]));
                check_field("running", 32'(want.running), 32'(m_tdata[OUT_RUNNING]));
                check_field("implausible", 32'(want.implausible),
                            32'(m_tdata[OUT_IMPLAUS]));
                check_field("shutdown", 32'(want.shutdown), 32'(m_tdata[OUT_SHUTDOWN]));
                check_field("throttle_avg", 32'($signed(want.throttle_avg)),
                            32'($signed(m_tdata[OUT_AVG_LSB +: 16])));
            end
            results_seen++;
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pedal_plausibility_ready_to_drive test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_ready_to_drive();
        test_plausibility_shutdown();
        test_random_traffic();
        test_backpressure();
        wait_idle();
        if (mismatches == 0) begin
            $display("pedal_plausibility_ready_to_drive test passed");
        end else begin
            $display("pedal_plausibility_ready_to_drive test failed");
        end
        $finish;
    end

endmodule

[pedal_plausibility_ready_to_drive.f]
+incdir+hw/rtl
hw/rtl/pprtd_pkg.sv
hw/rtl/pprtd_cfg.sv
hw/rtl/pprtd_front.sv
hw/rtl/pprtd_ctrl.sv
hw/rtl/pedal_plausibility_ready_to_drive.sv
tb/tb.sv
